// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define CHK_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("port check failed");

// checked on every edge, reset included
`define CHK_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("reset check failed");

`endif

// File: hw/rtl/ecbbr_pkg.sv
// ----------------------------------------------------------------------------
// ecbbr_pkg
// shared constants, item types and back-end states of the row box blur
// ----------------------------------------------------------------------------
`default_nettype none

package ecbbr_pkg;

  localparam int PIX_W      = 8;
  localparam int PIX_MAX    = (1 << PIX_W) - 1;
  localparam int RAD_W      = 5;
  localparam int MAX_RADIUS = 31;
  localparam int RW         = $clog2(MAX_RADIUS + 1);
  localparam int DMAX       = 2 * MAX_RADIUS + 1;
  localparam int CNT_W      = $clog2(DMAX + 1);
  localparam int ADDR_W     = $clog2(DMAX + 1);
  localparam int SUM_W      = $clog2(DMAX * PIX_MAX + 1);
  localparam int NUM_W      = $clog2(DMAX * PIX_MAX + MAX_RADIUS + 1);
  localparam int REC_SH     = NUM_W + CNT_W;
  localparam int REC_W      = REC_SH + 1;

  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_in_row;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic             row_end;
  } out_item_t;

  // classified pixel handed from the front to the back
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             first;
    logic             emit;
    logic [CNT_W-1:0] newest;
    logic [RW-1:0]    rad;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_RC_RD,
    ST_RC_ADD,
    ST_FL_RD,
    ST_FL_ADD,
    ST_MUL,
    ST_PUSH
  } back_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/ecbbr_fifo.sv
// ----------------------------------------------------------------------------
// ecbbr_fifo
// small register queue with full and empty flags
// ----------------------------------------------------------------------------
`default_nettype none

module ecbbr_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      fill;
  logic             wr_en;
  logic             rd_en;

  assign full  = (fill == (PW + 1)'(DEPTH));
  assign empty = (fill == '0);
  assign wr_en = wr && !full;
  assign rd_en = rd && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ecbbr_front.sv
// ----------------------------------------------------------------------------
// ecbbr_front
// radius register, row position count and pixel classification
// ----------------------------------------------------------------------------
`default_nettype none

module ecbbr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [ecbbr_pkg::RAD_W-1:0] cfg_data,
  input  logic                        push,
  input  ecbbr_pkg::in_item_t         sample,
  output logic                        full,
  output logic                        cmd_push,
  output ecbbr_pkg::cmd_t             cmd,
  input  logic                        cmd_full
);

  import ecbbr_pkg::*;

  logic [RAD_W-1:0] radius;
  logic [CNT_W-1:0] count;
  logic [RW-1:0]    eff_r;
  logic             accept;

  // radius in use is capped at the largest supported window
  always_comb begin
    if (int'(radius) > MAX_RADIUS) begin
      eff_r = RW'(MAX_RADIUS);
    end else begin
      eff_r = RW'(radius);
    end
  end

  assign full     = cmd_full;
  assign accept   = push && !cmd_full;
  assign cmd_push = accept;

  assign cmd.pixel  = sample.pixel;
  assign cmd.last   = sample.last_in_row;
  assign cmd.first  = (count == '0);
  assign cmd.emit   = (count >= CNT_W'(eff_r));
  assign cmd.newest = count;
  assign cmd.rad    = eff_r;

  // count only matters against 2r+1, so it saturates at the widest window
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
      count  <= '0;
    end else begin
      if (cfg_write) begin
        radius <= cfg_data;
      end
      if (accept) begin
        if (sample.last_in_row) begin
          count <= '0;
        end else if (count != CNT_W'(DMAX)) begin
          count <= count + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ecbbr_back.sv
// ----------------------------------------------------------------------------
// ecbbr_back
// window store, running sum upkeep, row-end flush and rounded mean
// ----------------------------------------------------------------------------
`default_nettype none

module ecbbr_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_empty,
  input  ecbbr_pkg::cmd_t      cmd,
  output logic                 cmd_pop,
  input  logic                 out_full,
  output logic                 out_push,
  output ecbbr_pkg::out_item_t out_item
);

  import ecbbr_pkg::*;

  localparam longint unsigned TWO_K = 64'd1 << REC_SH;

  back_state_t              state;
  back_state_t              state_next;
  cmd_t                     cur;
  logic [PIX_W-1:0]         store [2**ADDR_W];
  logic [PIX_W-1:0]         rd_data;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wp;
  logic [ADDR_W-1:0]        newest_slot;
  logic [PIX_W-1:0]         first_value;
  logic [SUM_W-1:0]         wsum;
  logic [RW-1:0]            rad_sum;
  logic [CNT_W-1:0]         bcnt;
  logic                     sub_first;
  logic [PIX_W-1:0]         sub_val;
  logic [SUM_W-1:0]         step_sum;
  logic [SUM_W-1:0]         init_sum;
  logic [CNT_W-1:0]         dia_cmd;
  logic [CNT_W-1:0]         span2;
  logic [NUM_W-1:0]         num;
  logic [REC_W-1:0]         recip_tab [MAX_RADIUS+1];
  logic [NUM_W+REC_W-1:0]   prod;

  // reciprocal of each window size, exact for every numerator in range
  for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_recip
    localparam longint unsigned DIV = 2 * g + 1;
    localparam longint unsigned MG  = (TWO_K + DIV - 1) / DIV;
    assign recip_tab[g] = MG[REC_W-1:0];
  end

  // next step after the window sum is ready: output now, walk the flush, or done
  function automatic back_state_t route_of(input cmd_t c, input logic [CNT_W-1:0] k);
    logic [CNT_W:0] reach;
    reach = {1'b0, c.newest} + {1'b0, k};
    if (!c.last) begin
      return c.emit ? ST_MUL : ST_IDLE;
    end else if (reach >= (CNT_W + 1)'(c.rad)) begin
      return ST_MUL;
    end else begin
      return ST_FL_RD;
    end
  endfunction

  assign dia_cmd  = CNT_W'({cmd.rad, 1'b1});
  assign span2    = CNT_W'({cur.rad, 1'b0});
  assign sub_val  = sub_first ? first_value : rd_data;
  assign init_sum = SUM_W'(dia_cmd) * SUM_W'(cmd.pixel);
  assign step_sum = wsum + SUM_W'(cur.pixel) - SUM_W'(sub_val);
  assign num      = NUM_W'(wsum) + NUM_W'(cur.rad);

  // rounded mean: floor((S + r) / (2r + 1)) by reciprocal multiply
  assign out_item.blurred = prod[REC_SH +: PIX_W];
  assign out_item.row_end = cur.last && (bcnt == CNT_W'(cur.rad));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    out_push   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = newest_slot;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.first) begin
            state_next = route_of(cmd, '0);
          end else if (cmd.rad != rad_sum) begin
            state_next = ST_RC_RD;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = wp - ADDR_W'(dia_cmd);
            state_next = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        state_next = route_of(cur, '0);
      end
      ST_RC_RD: begin
        if (bcnt > span2) begin
          state_next = route_of(cur, '0);
        end else begin
          rd_en      = 1'b1;
          rd_addr    = newest_slot - ADDR_W'(bcnt);
          state_next = ST_RC_ADD;
        end
      end
      ST_RC_ADD: begin
        state_next = ST_RC_RD;
      end
      ST_FL_RD: begin
        rd_en      = 1'b1;
        rd_addr    = newest_slot - ADDR_W'(span2 - bcnt);
        state_next = ST_FL_ADD;
      end
      ST_FL_ADD: begin
        state_next = route_of(cur, bcnt + CNT_W'(1));
      end
      ST_MUL: begin
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_full) begin
          out_push = 1'b1;
          if (cur.last && (bcnt != CNT_W'(cur.rad))) begin
            state_next = ST_FL_RD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      store[wp] <= cmd.pixel;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      rad_sum <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!cmd_empty) begin
            cur         <= cmd;
            newest_slot <= wp;
            wp          <= wp + 1'b1;
            bcnt        <= '0;
            if (cmd.first) begin
              // everything left of the row start reads as the first pixel
              first_value <= cmd.pixel;
              wsum        <= init_sum;
              rad_sum     <= cmd.rad;
            end else if (cmd.rad != rad_sum) begin
              // radius changed mid row: rebuild the sum from the store
              wsum    <= SUM_W'(cmd.pixel);
              rad_sum <= cmd.rad;
              bcnt    <= CNT_W'(1);
            end else begin
              sub_first <= (cmd.newest < dia_cmd);
            end
          end
        end
        ST_UPD: begin
          wsum <= step_sum;
        end
        ST_RC_RD: begin
          if (bcnt > span2) begin
            bcnt <= '0;
          end else begin
            sub_first <= (bcnt > cur.newest);
          end
        end
        ST_RC_ADD: begin
          wsum <= wsum + SUM_W'(sub_val);
          bcnt <= bcnt + 1'b1;
        end
        ST_FL_RD: begin
          sub_first <= (cur.newest < (span2 - bcnt));
        end
        ST_FL_ADD: begin
          wsum <= step_sum;
          bcnt <= bcnt + 1'b1;
        end
        ST_MUL: begin
          prod <= num * recip_tab[cur.rad];
        end
        ST_PUSH: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/edge_clamped_box_blur_row.sv
// ----------------------------------------------------------------------------
// edge_clamped_box_blur_row
// box blur along one row of 8-bit alpha pixels with clamped row edges
// ----------------------------------------------------------------------------
// usage
//   input queue: drive sample and push; the item is taken when full is low.
//   set last_in_row on the row's final pixel; it releases the pending outputs.
//   result queue: result is valid while empty is low; pop takes the item.
//   radius: cfg_write with cfg_data loads the half-width; the user must write
//   it only while idle, the block itself does not enforce this.
// back-end steps
//   a mid-row pixel that releases an output goes through store read, sum
//   update, reciprocal multiply and queue write; one that releases nothing
//   ends after the sum update. a row's first pixel loads the sum directly and
//   at radius 0 also goes through multiply and queue write. the window store has
//   one read port. a row's last pixel walks the flush: a store read and sum
//   update per position, then multiply and queue write per released output.
//   a mid-row radius change turns the sum update into a store rebuild, once.
// reset and stall
//   rst clears both queues, the row count and radius (pass-through);
//   a stalled receiver fills the result queue, then the back end waits,
//   then the command queue fills and full goes high.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_clamped_box_blur_row #(
  parameter int CMD_DEPTH = ecbbr_pkg::CMDQ_DEPTH,
  parameter int OUT_DEPTH = ecbbr_pkg::OUTQ_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [ecbbr_pkg::RAD_W-1:0] cfg_data,
  input  logic                        push,
  input  ecbbr_pkg::in_item_t         sample,
  output logic                        full,
  input  logic                        pop,
  output ecbbr_pkg::out_item_t        result,
  output logic                        empty
);

  import ecbbr_pkg::*;

  // front to back command path
  cmd_t      cmd_wdata;
  cmd_t      cmd_rdata;
  logic      cmd_push;
  logic      cmd_full;
  logic      cmd_pop;
  logic      cmd_empty;

  // back to result queue
  out_item_t out_wdata;
  logic      out_push;
  logic      out_full;

  // front: radius register, row count, classification of each item
  ecbbr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .push      (push),
    .sample    (sample),
    .full      (full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_wdata),
    .cmd_full  (cmd_full)
  );

  // short queue so the front keeps taking items while the back works
  ecbbr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .rd    (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  // back: store, running sum, flush walk, rounded mean
  ecbbr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_wdata)
  );

  // result queue decouples the back end from receiver stalls
  ecbbr_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .rd    (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ecbbr_checker.sv
// ----------------------------------------------------------------------------
// ecbbr_checker
// port-level checks of the row box blur, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ecbbr_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 full,
  input logic                 pop,
  input logic                 empty,
  input ecbbr_pkg::out_item_t result
);

  // reset drops every queued item
  `CHK_ASSERT_RST(a_reset_empty, rst |=> empty)
  // reset leaves room for a new item
  `CHK_ASSERT_RST(a_reset_not_full, rst |=> !full)
  // a waiting item stays put until popped
  `CHK_ASSERT(a_result_held, (!empty && !pop) |=> (!empty && $stable(result)))

endmodule

bind edge_clamped_box_blur_row ecbbr_checker u_ecbbr_checker (.*);

`default_nettype wire
